// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check on every rising edge, skipped while reset is high
`define LPSB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lpsb assertion failed");
// check on every rising edge, reset included
`define LPSB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lpsb assertion failed");
`else
`define LPSB_ASSERT(lbl, clk, rst, prop)
`define LPSB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/lpsb_pkg.sv =====
// ----------------------------------------------------------------------------
// lpsb_pkg
// types and constants of the lcd pixel plot shadow buffer
// ----------------------------------------------------------------------------
`default_nettype none

package lpsb_pkg;

   localparam int PAGES_DEF   = 8;
   localparam int COLUMNS_DEF = 132;

   localparam logic [7:0] CMD_START_LINE = 8'h40;
   localparam logic [3:0] CMD_PAGE       = 4'hB;
   localparam logic [3:0] CMD_COL_HIGH   = 4'h1;
   localparam logic [3:0] CMD_COL_LOW    = 4'h0;

   localparam logic ACTION_PLOT  = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] column;
      logic [5:0] row;
      logic       bottom_origin;
   } req_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      STEP_START,
      STEP_PAGE,
      STEP_COL_HIGH,
      STEP_COL_LOW,
      STEP_DATA
   } step_type;

endpackage

`default_nettype wire

// ===== rtl/core/lpsb_ram.sv =====
// ----------------------------------------------------------------------------
// lpsb_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lpsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1056,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lcd_pixel_plot_shadow_buffer.sv =====
// ----------------------------------------------------------------------------
// lcd_pixel_plot_shadow_buffer
// pixel-set engine with a page/column shadow store for a graphic lcd
// ----------------------------------------------------------------------------
// A plot request sets one pixel in the shadow store and is answered with five
// bus writes: start line, page address, column high, column low (commands)
// and the updated byte (data, last set). The writes leave at one per cycle
// while rsp_stall is low, the first in the cycle after the request is taken;
// the next request is taken in the cycle the data write is taken, so plots
// are paced by the five writes on the response side. The read-modify-write
// of the store fits under the command writes. A plot with a column or row
// outside the display is dropped. After reset and after a clear request the
// store is zeroed by a sweep over all PAGES*COLUMNS entries (1056 by
// default) through the memory's write port, during which requests stall.
`default_nettype none
`include "assert_macros.svh"

module lcd_pixel_plot_shadow_buffer #(
   parameter int PAGES   = lpsb_pkg::PAGES_DEF,
   parameter int COLUMNS = lpsb_pkg::COLUMNS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lpsb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lpsb_pkg::rsp_type      rsp_data
);

   localparam int DEPTH  = PAGES * COLUMNS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] COL_CNT   = ADDR_W'(COLUMNS);
   localparam logic [8:0]        COL_LIM   = 9'(COLUMNS);
   localparam logic [4:0]        PAGE_LIM  = 5'(PAGES);
   localparam logic [4:0]        PAGE_TOP  = 5'(PAGES - 1);

   lpsb_pkg::state_type state_ff, state_in;
   lpsb_pkg::step_type  step_ff, step_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [7:0]          col_ff, col_in;
   logic [7:0]          mask_ff, mask_in;
   logic [7:0]          value_ff, value_in;

   logic                req_accept;
   logic                rsp_accept;
   logic                col_ok;
   logic                band_ok;
   logic                plot_ok;
   logic [2:0]          band;
   logic [2:0]          bit_sel;
   logic [PAGE_W-1:0]   page_c;
   logic [7:0]          mask_c;
   logic [ADDR_W-1:0]   addr_c;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [7:0]          wr_data;
   logic                rd_en;
   logic [7:0]          rd_data;

   // address decode of the incoming request
   always_comb begin
      band    = req_data.row[5:3];
      col_ok  = {1'b0, req_data.column} < COL_LIM;
      band_ok = {2'b00, band} < PAGE_LIM;
      if (req_data.bottom_origin) begin
         page_c  = PAGE_W'(PAGE_TOP - {2'b00, band});
         bit_sel = 3'd7 - req_data.row[2:0];
      end else begin
         page_c  = PAGE_W'(band);
         bit_sel = req_data.row[2:0];
      end
      mask_c  = 8'd1 << bit_sel;
      addr_c  = ADDR_W'(ADDR_W'(page_c) * COL_CNT) + ADDR_W'(req_data.column);
      plot_ok = (req_data.action == lpsb_pkg::ACTION_PLOT) && col_ok && band_ok;
   end

   assign rsp_valid  = (state_ff == lpsb_pkg::ST_EMIT);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = !((state_ff == lpsb_pkg::ST_IDLE) ||
                         (rsp_accept && step_ff == lpsb_pkg::STEP_DATA));
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpsb_pkg::ST_CLEAR;
         step_ff  <= lpsb_pkg::STEP_START;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
      end
      addr_ff  <= addr_in;
      page_ff  <= page_in;
      col_ff   <= col_in;
      mask_ff  <= mask_in;
      value_ff <= value_in;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      clr_in   = clr_ff;
      pend_in  = 1'b0;
      addr_in  = addr_ff;
      page_in  = page_ff;
      col_in   = col_ff;
      mask_in  = mask_ff;
      value_in = value_ff;
      wr_en    = 1'b0;
      wr_addr  = addr_ff;
      wr_data  = rd_data | mask_ff;
      rd_en    = 1'b0;

      unique case (state_ff)
         lpsb_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == LAST_ADDR) begin
               state_in = lpsb_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         lpsb_pkg::ST_IDLE: begin
         end
         lpsb_pkg::ST_EMIT: begin
            // store read returned: merge the pixel and write it back
            if (pend_ff) begin
               wr_en    = 1'b1;
               value_in = rd_data | mask_ff;
            end
            if (rsp_accept) begin
               if (step_ff == lpsb_pkg::STEP_DATA) begin
                  state_in = lpsb_pkg::ST_IDLE;
               end else begin
                  step_in = lpsb_pkg::step_type'(step_ff + 3'd1);
               end
            end
         end
         default: begin
            state_in = lpsb_pkg::ST_IDLE;
         end
      endcase

      if (req_accept) begin
         if (req_data.action == lpsb_pkg::ACTION_CLEAR) begin
            state_in = lpsb_pkg::ST_CLEAR;
            clr_in   = '0;
         end else if (plot_ok) begin
            state_in = lpsb_pkg::ST_EMIT;
            step_in  = lpsb_pkg::STEP_START;
            pend_in  = 1'b1;
            addr_in  = addr_c;
            page_in  = page_c;
            col_in   = req_data.column;
            mask_in  = mask_c;
            rd_en    = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (step_ff)
         lpsb_pkg::STEP_START: begin
            rsp_data = '{is_data: 1'b0, bus_byte: lpsb_pkg::CMD_START_LINE, last: 1'b0};
         end
         lpsb_pkg::STEP_PAGE: begin
            rsp_data = '{is_data: 1'b0, bus_byte: {lpsb_pkg::CMD_PAGE, 4'(page_ff)},
                         last: 1'b0};
         end
         lpsb_pkg::STEP_COL_HIGH: begin
            rsp_data = '{is_data: 1'b0, bus_byte: {lpsb_pkg::CMD_COL_HIGH, col_ff[7:4]},
                         last: 1'b0};
         end
         lpsb_pkg::STEP_COL_LOW: begin
            rsp_data = '{is_data: 1'b0, bus_byte: {lpsb_pkg::CMD_COL_LOW, col_ff[3:0]},
                         last: 1'b0};
         end
         lpsb_pkg::STEP_DATA: begin
            rsp_data = '{is_data: 1'b1, bus_byte: value_ff, last: 1'b1};
         end
         default: begin
            rsp_data = '0;
         end
      endcase
   end

   lpsb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_c),
      .rd_data (rd_data)
   );

   // no request slips in while the store is being swept
   `LPSB_ASSERT_ALWAYS(a_clear_stalls, clock, (state_ff == lpsb_pkg::ST_CLEAR) |-> req_stall)
   // a valid plot starts its run on the very next cycle
   `LPSB_ASSERT(a_plot_starts, clock, reset, (req_accept && plot_ok) |=> (rsp_valid && step_ff == lpsb_pkg::STEP_START && pend_ff))
   // the sweep advances one entry per cycle
   `LPSB_ASSERT(a_sweep_steps, clock, reset, (state_ff == lpsb_pkg::ST_CLEAR && $past(state_ff == lpsb_pkg::ST_CLEAR) && !$past(reset) && !$past(req_accept)) |-> (clr_ff == $past(clr_ff) + 1'b1))

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// request/response testbench for the lcd pixel plot shadow buffer
// ----------------------------------------------------------------------------
// Plot and clear requests are pushed through the request channel. The bus
// writes that come back are checked in order against a shadow copy of the
// page/column store kept here. A short table of directed requests comes
// first, with hand-written writes where they are obvious. Random requests
// follow, mostly plots, many aimed at a few hot columns so that bytes fill up.
// Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lpsb_pkg::*;

   localparam int NUM_PAGES      = PAGES_DEF;
   localparam int NUM_COLUMNS    = COLUMNS_DEF;
   localparam int NUM_DIRECTED   = 20;
   localparam int RANDOM_ITEMS   = 210;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic       action;
      logic [7:0] column;
      logic [5:0] row;
      logic       bottom_origin;
      bit         typed;
      bit         writes;
      logic [7:0] page_cmd;
      logic [7:0] col_high_cmd;
      logic [7:0] col_low_cmd;
      logic [7:0] pixel_byte;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic [7:0] shadow_bytes [NUM_PAGES][NUM_COLUMNS];
   rsp_type    bus_writes_due [$];
   rsp_type    want;
   int         mismatches;
   int         idle_cycles;
   int         stall_hold;
   int         stall_pick;
   bit         calm_stretch;

   // expected writes typed in where they can be read straight off the request
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      // corners of the display, both orientations
      '{ACTION_PLOT,  8'd0,   6'd0,  1'b0, 1'b1, 1'b1, 8'hB0, 8'h10, 8'h00, 8'h01},
      '{ACTION_PLOT,  8'd131, 6'd63, 1'b0, 1'b1, 1'b1, 8'hB7, 8'h18, 8'h03, 8'h80},
      '{ACTION_PLOT,  8'd131, 6'd63, 1'b1, 1'b1, 1'b1, 8'hB0, 8'h18, 8'h03, 8'h01},
      '{ACTION_PLOT,  8'd0,   6'd0,  1'b1, 1'b1, 1'b1, 8'hB7, 8'h10, 8'h00, 8'h80},
      // columns off the display are dropped
      '{ACTION_PLOT,  8'd132, 6'd5,  1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_PLOT,  8'd255, 6'd63, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      // bits gather in bytes already written
      '{ACTION_PLOT,  8'd0,   6'd1,  1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_PLOT,  8'd0,   6'd7,  1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_PLOT,  8'd0,   6'd6,  1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_PLOT,  8'd77,  6'd37, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_PLOT,  8'd77,  6'd26, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      // clear ignores its other fields, then bytes start from zero again
      '{ACTION_CLEAR, 8'd200, 6'd45, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_PLOT,  8'd0,   6'd0,  1'b0, 1'b1, 1'b1, 8'hB0, 8'h10, 8'h00, 8'h01},
      '{ACTION_PLOT,  8'd131, 6'd63, 1'b0, 1'b1, 1'b1, 8'hB7, 8'h18, 8'h03, 8'h80},
      '{ACTION_PLOT,  8'd128, 6'd32, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_PLOT,  8'd15,  6'd8,  1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_CLEAR, 8'd131, 6'd0,  1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_PLOT,  8'd16,  6'd17, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_PLOT,  8'd16,  6'd17, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{ACTION_PLOT,  8'd130, 6'd56, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   lcd_pixel_plot_shadow_buffer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void push_write(input logic is_data, input logic [7:0] value);
      rsp_type w;
      w.is_data  = is_data;
      w.bus_byte = value;
      w.last     = is_data;
      bus_writes_due.push_back(w);
   endfunction

   // update the shadow copy and, if asked, queue the bus writes of the request
   function automatic void apply_pixel_request(input req_type r, input bit queue_writes);
      int page;
      int bitpos;
      if (r.action == ACTION_CLEAR) begin
         foreach (shadow_bytes[p, c]) shadow_bytes[p][c] = 8'h00;
         return;
      end
      if (int'(r.column) >= NUM_COLUMNS) return;
      if (int'(r.row[5:3]) >= NUM_PAGES) return;
      if (r.bottom_origin) begin
         page   = NUM_PAGES - 1 - int'(r.row[5:3]);
         bitpos = 7 - int'(r.row[2:0]);
      end else begin
         page   = int'(r.row[5:3]);
         bitpos = int'(r.row[2:0]);
      end
      shadow_bytes[page][r.column] = shadow_bytes[page][r.column] | 8'(1 << bitpos);
      if (!queue_writes) return;
      push_write(1'b0, CMD_START_LINE);
      push_write(1'b0, {CMD_PAGE, 4'(page)});
      push_write(1'b0, {CMD_COL_HIGH, r.column[7:4]});
      push_write(1'b0, {CMD_COL_LOW, r.column[3:0]});
      push_write(1'b1, shadow_bytes[page][r.column]);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_stretch || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // returns at the rising edge that takes the request
   task automatic send_request(input req_type r);
      int gap;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // response side back-pressure, in bursts of random length
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (calm_stretch || stall_pick >= 30) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 7);
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold <= (stall_pick < 25) ? $urandom_range(0, 2) : $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bus_writes_due.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected bus write: is_data=%0b byte=%02h last=%0b",
                        rsp_data.is_data, rsp_data.bus_byte, rsp_data.last);
         end else begin
            want = bus_writes_due.pop_front();
            if (rsp_data.is_data !== want.is_data || rsp_data.bus_byte !== want.bus_byte ||
                rsp_data.last !== want.last) begin
               mismatches = mismatches + 1;
               if (mismatches <= REPORT_LIMIT)
                  $display({"bus write mismatch: expected is_data=%0b byte=%02h last=%0b,",
                            " got is_data=%0b byte=%02h last=%0b"},
                           want.is_data, want.bus_byte, want.last,
                           rsp_data.is_data, rsp_data.bus_byte, rsp_data.last);
            end
         end
      end
   end

   // watchdog: a clear sweep is the longest legal quiet stretch
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[lcd_pixel_plot_shadow_buffer] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_type    r;
      logic [7:0] hot_cols [4];
      int         counted;
      int         pick;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      mismatches   = 0;
      idle_cycles  = 0;
      stall_hold   = 0;
      calm_stretch = 1'b0;
      foreach (shadow_bytes[p, c]) shadow_bytes[p][c] = 8'h00;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r.action        = directed_rows[i].action;
         r.column        = directed_rows[i].column;
         r.row           = directed_rows[i].row;
         r.bottom_origin = directed_rows[i].bottom_origin;
         send_request(r);
         apply_pixel_request(r, !directed_rows[i].typed);
         if (directed_rows[i].typed && directed_rows[i].writes) begin
            push_write(1'b0, CMD_START_LINE);
            push_write(1'b0, directed_rows[i].page_cmd);
            push_write(1'b0, directed_rows[i].col_high_cmd);
            push_write(1'b0, directed_rows[i].col_low_cmd);
            push_write(1'b1, directed_rows[i].pixel_byte);
         end
      end

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         // new hot columns and a fresh pressure mode every so often
         if (counted % 50 == 0) begin
            hot_cols[0] = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd131;
            for (int k = 1; k < 4; k++) hot_cols[k] = 8'($urandom_range(0, NUM_COLUMNS - 1));
            calm_stretch = ($urandom_range(0, 3) == 0);
         end
         pick            = $urandom_range(0, 99);
         r.row           = 6'($urandom_range(0, 63));
         r.bottom_origin = 1'($urandom_range(0, 1));
         r.column        = 8'($urandom_range(0, 255));
         if (pick < 3) begin
            r.action = ACTION_CLEAR;
            counted  = counted + 1;
         end else if (pick < 11) begin
            r.action = ACTION_PLOT;
            r.column = 8'($urandom_range(NUM_COLUMNS, 255));
         end else begin
            r.action = ACTION_PLOT;
            r.column = (pick < 60) ? hot_cols[$urandom_range(0, 3)]
                                   : 8'($urandom_range(0, NUM_COLUMNS - 1));
            counted  = counted + 1;
         end
         send_request(r);
         apply_pixel_request(r, 1'b1);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      calm_stretch = 1'b0;
      while (bus_writes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[lcd_pixel_plot_shadow_buffer] OK");
      end else begin
         $display("[lcd_pixel_plot_shadow_buffer] ERROR");
      end
      $finish;
   end

endmodule
